[rtl/assert_macros.svh]
// Assertion macros shared by the duty generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk with synchronous active-low reset
`define SVPWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked on clk with synchronous active-low reset
`define SVPWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

[rtl/svpwm_pkg.sv]
// Shared constants, tables and types of the space-vector PWM duty generator
package svpwm_pkg;

  localparam int PWM_PERIOD  = 256;
  localparam int TABLE_DEPTH = 128;

  localparam int ANG_W   = $clog2(TABLE_DEPTH);
  localparam int SEC_W   = 3;
  localparam int GAIN_W  = 4;
  localparam int ROM_W   = 10;
  localparam int DUTY_W  = 10;
  localparam int STEP_W  = 7;
  localparam int PAIR_W  = 2 * ROM_W;
  localparam int PROD_W  = ROM_W + GAIN_W;
  localparam int FILL_W  = ANG_W + 1;
  // signed working width, wide enough for 2*PWM_PERIOD over the full period range
  localparam int CALC_W  = 18;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(8);
  localparam logic [DUTY_W-1:0] DUTY_MAX   = '1;

  // sector codes
  localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
  localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
  localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
  localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
  localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
  localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

  // round(sin(theta)*1024), theta over 0..60 degrees
  localparam logic [ROM_W-1:0] SINE_ROM [TABLE_DEPTH] = '{
    10'd0,   10'd8,   10'd17,  10'd25,  10'd34,  10'd42,  10'd50,  10'd59,
    10'd67,  10'd75,  10'd84,  10'd92,  10'd100, 10'd109, 10'd117, 10'd125,
    10'd134, 10'd142, 10'd150, 10'd159, 10'd167, 10'd175, 10'd183, 10'd192,
    10'd200, 10'd208, 10'd216, 10'd224, 10'd233, 10'd241, 10'd249, 10'd257,
    10'd265, 10'd273, 10'd281, 10'd289, 10'd297, 10'd305, 10'd313, 10'd321,
    10'd329, 10'd337, 10'd345, 10'd353, 10'd361, 10'd369, 10'd376, 10'd384,
    10'd392, 10'd400, 10'd407, 10'd415, 10'd423, 10'd430, 10'd438, 10'd445,
    10'd453, 10'd460, 10'd468, 10'd475, 10'd483, 10'd490, 10'd497, 10'd505,
    10'd512, 10'd519, 10'd526, 10'd534, 10'd541, 10'd548, 10'd555, 10'd562,
    10'd569, 10'd576, 10'd583, 10'd590, 10'd596, 10'd603, 10'd610, 10'd617,
    10'd623, 10'd630, 10'd637, 10'd643, 10'd650, 10'd656, 10'd662, 10'd669,
    10'd675, 10'd681, 10'd688, 10'd694, 10'd700, 10'd706, 10'd712, 10'd718,
    10'd724, 10'd730, 10'd736, 10'd742, 10'd747, 10'd753, 10'd759, 10'd764,
    10'd770, 10'd775, 10'd781, 10'd786, 10'd792, 10'd797, 10'd802, 10'd807,
    10'd812, 10'd817, 10'd822, 10'd827, 10'd832, 10'd837, 10'd842, 10'd847,
    10'd851, 10'd856, 10'd861, 10'd865, 10'd870, 10'd874, 10'd878, 10'd883
  };

  // per-beat tag that travels with the table lookup
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [SEC_W-1:0]  sector;
    logic [ANG_W-1:0]  angle;
  } tag_t;

  // table RAM write port during the fill sweep
  typedef struct packed {
    logic              en;
    logic [ANG_W-1:0]  addr;
    logic [PAIR_W-1:0] data;
  } ram_wr_t;

  // stage load strobes
  typedef struct packed {
    logic load2;
    logic load3;
  } pipe_ctl_t;

endpackage

[rtl/space_vector_pwm_duty_generator.sv]
// Top level of the space-vector PWM duty generator
//
// Input channel in_valid/in_stall carries one tick beat with a 4-bit gain.
// Each accepted beat advances the in-sector angle by cfg_angle_step (carry
// moves the sector on, modulo 6) and yields one result beat on
// out_valid/out_stall: three phase compare values, sector and angle.
// Each beat passes the table RAM read, the gain multiply and the duty select,
// each of which occupies one registered stage. Throughput is one beat per
// cycle while out_stall does not hold the pipeline, and the angle
// accumulator takes a new step on every accepted beat.
// The sine table sits in a RAM whose entries hold a sine pair for a and
// 127-a, so one read port serves both dwell times.
// After reset a fill sweep loads all 128 table entries; in_stall stays
// high until it ends. Angle and sector reset to 0, angle_step to 8.
// cfg_ready is always high; write the step only while the block is idle.
// A stall on the output holds the result register; the stages behind it
// keep filling, so up to three beats are held before in_stall rises.
`include "assert_macros.svh"

module space_vector_pwm_duty_generator
  import svpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [GAIN_W-1:0] in_gain,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DUTY_W-1:0] out_duty_r,
  output logic [DUTY_W-1:0] out_duty_y,
  output logic [DUTY_W-1:0] out_duty_b,
  output logic [SEC_W-1:0]  out_sector_out,
  output logic [ANG_W-1:0]  out_angle_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_angle_step
);

  logic [STEP_W-1:0] step_r;
  logic [ANG_W-1:0]  angle_r;
  logic [ANG_W-1:0]  angle_nxt;
  logic [SEC_W-1:0]  sector_r;
  logic [SEC_W-1:0]  sector_nxt;
  logic [ANG_W:0]    sum;
  logic              v1_r;
  logic              v2_r;
  logic              v3_r;
  logic              en1;
  logic              en2;
  logic              en3;
  logic              accept;
  logic              fill_busy;
  ram_wr_t           ram_wr;
  tag_t              tag1_r;
  logic [PAIR_W-1:0] pair;
  pipe_ctl_t         ctl;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_r <= cfg_angle_step;
    end
  end

  // stage enables: a stage loads when empty or when its successor moves
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = fill_busy || !en1;
  assign accept   = in_valid && !in_stall;

  // advance angle and sector
  assign sum       = {1'b0, angle_r} + (ANG_W+1)'(step_r);
  assign angle_nxt = sum[ANG_W-1:0];
  always_comb begin
    sector_nxt = sector_r;
    if (sum[ANG_W]) begin
      sector_nxt = (sector_r >= SEC_5) ? SEC_0 : sector_r + SEC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r  <= '0;
      sector_r <= SEC_0;
    end else if (accept) begin
      angle_r  <= angle_nxt;
      sector_r <= sector_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= accept;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // tag that rides alongside the table read
  always_ff @(posedge clk) begin
    if (accept) begin
      tag1_r <= '{gain: in_gain, sector: sector_nxt, angle: angle_nxt};
    end
  end

  svpwm_rom_fill u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (fill_busy),
    .wr    (ram_wr)
  );

  svpwm_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (accept),
    .rd_addr (angle_nxt),
    .rd_data (pair)
  );

  assign ctl.load2 = en2 && v1_r;
  assign ctl.load3 = en3 && v2_r;

  svpwm_duty u_duty (
    .clk     (clk),
    .ctl     (ctl),
    .tag_in  (tag1_r),
    .pair_in (pair),
    .duty_r  (out_duty_r),
    .duty_y  (out_duty_y),
    .duty_b  (out_duty_b),
    .sector  (out_sector_out),
    .angle   (out_angle_out)
  );

  assign out_valid = v3_r;

  // checks
  `SVPWM_ASSERT_IMP(a_no_accept_in_fill, fill_busy, in_stall)
  `SVPWM_ASSERT_IMP(a_sector_range, 1'b1, sector_r <= SEC_5)
  `SVPWM_ASSERT_NXT(a_accept_fills_s1, accept, v1_r)
  `SVPWM_ASSERT_NXT(a_zero_step_holds, accept && (step_r == '0), angle_r == $past(angle_r))

endmodule

[rtl/svpwm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data
module svpwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/svpwm_rom_fill.sv]
// Fill sweep that loads sine pairs into the table RAM after reset
module svpwm_rom_fill
  import svpwm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  output logic    busy,
  output ram_wr_t wr
);

  logic [FILL_W-1:0] cnt_r;
  logic [FILL_W-1:0] cnt_nxt;
  logic [ANG_W-1:0]  addr;
  logic [ANG_W-1:0]  mirror;

  assign busy    = !cnt_r[FILL_W-1];
  assign cnt_nxt = busy ? cnt_r + FILL_W'(1) : cnt_r;

  // advance one entry a cycle until the top bit sets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // entry a holds {sin(a), sin(last - a)}
  assign addr    = cnt_r[ANG_W-1:0];
  assign mirror  = ANG_W'(TABLE_DEPTH - 1) - addr;
  assign wr.en   = busy;
  assign wr.addr = addr;
  assign wr.data = {SINE_ROM[addr], SINE_ROM[mirror]};

endmodule

[rtl/svpwm_duty.sv]
// Dwell-time scaling, half zero time and per-sector duty selection
module svpwm_duty
  import svpwm_pkg::*;
(
  input  logic              clk,
  input  pipe_ctl_t         ctl,
  input  tag_t              tag_in,
  input  logic [PAIR_W-1:0] pair_in,
  output logic [DUTY_W-1:0] duty_r,
  output logic [DUTY_W-1:0] duty_y,
  output logic [DUTY_W-1:0] duty_b,
  output logic [SEC_W-1:0]  sector,
  output logic [ANG_W-1:0]  angle
);

  logic [PROD_W-1:0]        prod_b;
  logic [PROD_W-1:0]        prod_a;
  logic [ROM_W-1:0]         tb_r;
  logic [ROM_W-1:0]         ta_r;
  tag_t                     tag2_r;
  logic signed [CALC_W-1:0] two_p;
  logic signed [CALC_W-1:0] ta_s;
  logic signed [CALC_W-1:0] tb_s;
  logic signed [CALC_W-1:0] num;
  logic signed [CALC_W-1:0] t02;
  logic signed [CALC_W-1:0] pos_a;
  logic signed [CALC_W-1:0] pos_b;
  logic signed [CALC_W-1:0] neg;
  logic signed [CALC_W-1:0] r_val;
  logic signed [CALC_W-1:0] y_val;
  logic signed [CALC_W-1:0] b_val;

  function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [CALC_W-1:0] v);
    logic [DUTY_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(CALC_W-DUTY_W){1'b0}}, DUTY_MAX})) begin
      res = DUTY_MAX;
    end else begin
      res = v[DUTY_W-1:0];
    end
    return res;
  endfunction

  // scale both table values by gain/16
  assign prod_b = PROD_W'(pair_in[PAIR_W-1:ROM_W]) * PROD_W'(tag_in.gain);
  assign prod_a = PROD_W'(pair_in[ROM_W-1:0]) * PROD_W'(tag_in.gain);

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      tb_r   <= prod_b[PROD_W-1:GAIN_W];
      ta_r   <= prod_a[PROD_W-1:GAIN_W];
      tag2_r <= tag_in;
    end
  end

  // half zero-vector time, clamped at zero under overmodulation
  assign two_p = CALC_W'(2 * PWM_PERIOD);
  assign ta_s  = $signed({{(CALC_W-ROM_W){1'b0}}, ta_r});
  assign tb_s  = $signed({{(CALC_W-ROM_W){1'b0}}, tb_r});
  assign num   = two_p - ta_s - tb_s;
  assign t02   = num[CALC_W-1] ? '0 : (num >>> 1);
  assign pos_a = t02 + ta_s;
  assign pos_b = t02 + tb_s;
  assign neg   = two_p - t02;

  // pick phase compares by sector; unknown codes follow sector 5
  always_comb begin
    case (tag2_r.sector)
      SEC_0: begin
        r_val = t02;   y_val = pos_a; b_val = neg;
      end
      SEC_1: begin
        r_val = pos_b; y_val = t02;   b_val = neg;
      end
      SEC_2: begin
        r_val = neg;   y_val = t02;   b_val = pos_a;
      end
      SEC_3: begin
        r_val = neg;   y_val = pos_b; b_val = t02;
      end
      SEC_4: begin
        r_val = pos_a; y_val = neg;   b_val = t02;
      end
      default: begin
        r_val = t02;   y_val = neg;   b_val = pos_b;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load3) begin
      duty_r <= sat_duty(r_val);
      duty_y <= sat_duty(y_val);
      duty_b <= sat_duty(b_val);
      sector <= tag2_r.sector;
      angle  <= tag2_r.angle;
    end
  end

endmodule
